/* rtl/core/stxfrm_pkg.sv */
// ----------------------------------------------------------------------------
// stxfrm_pkg
// Shared types, constants and control bundles of the STX / length / CRC-16
// packet framer.
// ----------------------------------------------------------------------------
package stxfrm_pkg;

   // buffer geometry
   localparam int BUF_BYTES = 32;
   localparam int IDX_W     = $clog2(BUF_BYTES);
   localparam int CNT_W     = $clog2(BUF_BYTES + 1);

   // frame format
   localparam logic [7:0] STX_BYTE  = 8'd2;
   localparam logic [7:0] MIN_FRAME = 8'd6;
   localparam logic [7:0] CRC_BYTES = 8'd2;

   // counter and register widths
   localparam int TICK_W = 24;
   localparam int CRC_W  = 16;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // register reset values
   localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST = 24'd750000;
   localparam logic [CRC_W-1:0]  CRC_POLY_RST     = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_SEED_RST     = 16'hFFFF;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_NOTICE  = 1'b1;

   // request and response payloads
   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [TICK_W-1:0] idle_timeout;
      logic [CRC_W-1:0]  crc_poly;
      logic [CRC_W-1:0]  crc_seed;
   } cfg_type;

   // buffer read offset select, relative to the head of the buffer
   typedef enum logic [1:0] {
      RD_HEAD = 2'd0,
      RD_LEN  = 2'd1,
      RD_IDX  = 2'd2
   } rd_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic       tick;
      logic       take_byte;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       drop_one;
      logic       drop_len;
      logic       len_load;
      logic       crc_init;
      logic       crc_step;
      logic       rxlo_load;
      logic       idx_inc;
      logic       idx_emit;
      logic       push_notice;
      logic       push_byte;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic count_lt2;
      logic head_is_stx;
      logic len_big;
      logic len_gt_count;
      logic len_small;
      logic crc_done;
      logic crc_ok;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/stxfrm_csr.sv */
// ----------------------------------------------------------------------------
// stxfrm_csr
// APB-style register file: idle timeout, CRC polynomial and CRC seed.
// ----------------------------------------------------------------------------
module stxfrm_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output stxfrm_pkg::cfg_type    cfg
);

   localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_CRC_POLY     = 2'd1;
   localparam logic [1:0] REG_CRC_SEED     = 2'd2;

   logic [stxfrm_pkg::TICK_W-1:0] idle_timeout_ff, idle_timeout_in;
   logic [stxfrm_pkg::CRC_W-1:0]  crc_poly_ff, crc_poly_in;
   logic [stxfrm_pkg::CRC_W-1:0]  crc_seed_ff, crc_seed_in;
   logic                          wr_en;
   logic [1:0]                    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register write decode
   always_comb begin
      idle_timeout_in = idle_timeout_ff;
      crc_poly_in     = crc_poly_ff;
      crc_seed_in     = crc_seed_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_IDLE_TIMEOUT: idle_timeout_in = csr_pwdata[stxfrm_pkg::TICK_W-1:0];
            REG_CRC_POLY:     crc_poly_in     = csr_pwdata[stxfrm_pkg::CRC_W-1:0];
            REG_CRC_SEED:     crc_seed_in     = csr_pwdata[stxfrm_pkg::CRC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= stxfrm_pkg::IDLE_TIMEOUT_RST;
         crc_poly_ff     <= stxfrm_pkg::CRC_POLY_RST;
         crc_seed_ff     <= stxfrm_pkg::CRC_SEED_RST;
      end else begin
         idle_timeout_ff <= idle_timeout_in;
         crc_poly_ff     <= crc_poly_in;
         crc_seed_ff     <= crc_seed_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_IDLE_TIMEOUT: csr_prdata = 32'(idle_timeout_ff);
         REG_CRC_POLY:     csr_prdata = 32'(crc_poly_ff);
         REG_CRC_SEED:     csr_prdata = 32'(crc_seed_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.idle_timeout = idle_timeout_ff;
   assign cfg.crc_poly     = crc_poly_ff;
   assign cfg.crc_seed     = crc_seed_ff;

endmodule

/* rtl/core/stxfrm_ctrl.sv */
// ----------------------------------------------------------------------------
// stxfrm_ctrl
// Framing sequencer: takes requests, scans for STX, checks length and CRC,
// and steps payload bytes or notices out through the datapath.
// ----------------------------------------------------------------------------
module stxfrm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_ready,
   input  stxfrm_pkg::status_type sts,
   output stxfrm_pkg::cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'h0001,
      ST_CHK_HEAD  = 13'h0002,
      ST_WAIT_HEAD = 13'h0004,
      ST_WAIT_LEN  = 13'h0008,
      ST_CHK_LEN   = 13'h0010,
      ST_CRC_RD    = 13'h0020,
      ST_CRC_STEP  = 13'h0040,
      ST_WAIT_LO   = 13'h0080,
      ST_RD_HI     = 13'h0100,
      ST_CHK_CRC   = 13'h0200,
      ST_NOTICE    = 13'h0400,
      ST_EMIT_RD   = 13'h0800,
      ST_EMIT      = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = stxfrm_pkg::RD_HEAD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  cmd.tick = 1'b1;
               end else begin
                  cmd.take_byte = 1'b1;
                  state_in      = ST_CHK_HEAD;
               end
            end
         end
         // read the byte at the head of the buffer
         ST_CHK_HEAD: begin
            if (sts.count_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stxfrm_pkg::RD_HEAD;
               state_in   = ST_WAIT_HEAD;
            end
         end
         // drop leading non-STX bytes one at a time
         ST_WAIT_HEAD: begin
            if (!sts.head_is_stx) begin
               cmd.drop_one = 1'b1;
               state_in     = ST_CHK_HEAD;
            end else if (sts.count_lt2) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stxfrm_pkg::RD_LEN;
               state_in   = ST_WAIT_LEN;
            end
         end
         ST_WAIT_LEN: begin
            cmd.len_load = 1'b1;
            state_in     = ST_CHK_LEN;
         end
         // length checks, incomplete frame waits for more bytes
         ST_CHK_LEN: begin
            if (sts.len_big) begin
               state_in = ST_NOTICE;
            end else if (sts.len_gt_count) begin
               state_in = ST_IDLE;
            end else if (sts.len_small) begin
               state_in = ST_NOTICE;
            end else begin
               cmd.crc_init = 1'b1;
               state_in     = ST_CRC_RD;
            end
         end
         // one buffer byte per read, then the low CRC byte
         ST_CRC_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = stxfrm_pkg::RD_IDX;
            state_in   = sts.crc_done ? ST_WAIT_LO : ST_CRC_STEP;
         end
         ST_CRC_STEP: begin
            cmd.crc_step = 1'b1;
            state_in     = ST_CRC_RD;
         end
         ST_WAIT_LO: begin
            cmd.rxlo_load = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = stxfrm_pkg::RD_IDX;
            state_in   = ST_CHK_CRC;
         end
         ST_CHK_CRC: begin
            if (sts.crc_ok) begin
               cmd.idx_emit = 1'b1;
               state_in     = ST_EMIT_RD;
            end else begin
               state_in = ST_NOTICE;
            end
         end
         // bad frame: one notice, drop the STX, rescan
         ST_NOTICE: begin
            if (sts.out_free) begin
               cmd.push_notice = 1'b1;
               cmd.drop_one    = 1'b1;
               state_in        = ST_CHK_HEAD;
            end
         end
         // payload bytes out, then drop the whole frame
         ST_EMIT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = stxfrm_pkg::RD_IDX;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.push_byte = 1'b1;
               cmd.idx_inc   = 1'b1;
               if (sts.emit_last) begin
                  cmd.drop_len = 1'b1;
                  state_in     = ST_CHK_HEAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/stxfrm_dp.sv */
// ----------------------------------------------------------------------------
// stxfrm_dp
// Framer datapath: circular byte buffer, fill count, idle counter, length
// and CRC registers, and the response output register.
// ----------------------------------------------------------------------------
module stxfrm_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             rx_byte,
   input  stxfrm_pkg::cfg_type    cfg,
   input  stxfrm_pkg::cmd_type    cmd,
   output stxfrm_pkg::status_type sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stxfrm_pkg::rsp_type    rsp_data
);

   localparam int IDX_W = stxfrm_pkg::IDX_W;
   localparam int CNT_W = stxfrm_pkg::CNT_W;
   localparam int SUM_W = CNT_W + 1;

   // head plus offset, wrapped at the buffer size
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(off);
      if (sum >= SUM_W'(stxfrm_pkg::BUF_BYTES)) begin
         sum = sum - SUM_W'(stxfrm_pkg::BUF_BYTES);
      end
      return sum[IDX_W-1:0];
   endfunction

   // one byte through the MSB-first CRC register
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] crc;
      crc = crc_in ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ poly;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      return crc;
   endfunction

   logic [7:0] frame_mem [stxfrm_pkg::BUF_BYTES];

   logic [IDX_W-1:0]              head_ff, head_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [stxfrm_pkg::TICK_W-1:0] idle_ff, idle_in;
   logic [7:0]                    rd_ff;
   logic [7:0]                    len_ff;
   logic [7:0]                    rxlo_ff;
   logic [15:0]                   crc_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   stxfrm_pkg::rsp_type           rsp_ff;

   logic                          timed_out;
   logic [CNT_W-1:0]              eff_count;
   logic                          full;
   logic [IDX_W-1:0]              wr_addr;
   logic [IDX_W-1:0]              rd_addr;
   logic [CNT_W-1:0]              rd_off;

   // timeout flush and append position
   assign timed_out = (count_ff != '0) && (idle_ff > cfg.idle_timeout);
   assign eff_count = timed_out ? '0 : count_ff;
   assign full      = (eff_count >= CNT_W'(stxfrm_pkg::BUF_BYTES));
   assign wr_addr   = wrap_add(head_ff, eff_count);

   // read address
   always_comb begin
      case (cmd.rd_sel)
         stxfrm_pkg::RD_HEAD: rd_off = '0;
         stxfrm_pkg::RD_LEN:  rd_off = CNT_W'(1);
         stxfrm_pkg::RD_IDX:  rd_off = CNT_W'(idx_ff);
         default:             rd_off = '0;
      endcase
   end
   assign rd_addr = wrap_add(head_ff, rd_off);

   // buffer memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.take_byte && !full) begin
         frame_mem[wr_addr] <= rx_byte;
      end
      if (cmd.rd_en) begin
         rd_ff <= frame_mem[rd_addr];
      end
   end

   // head, fill count and idle counter
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      idle_in  = idle_ff;
      if (cmd.tick && (idle_ff != stxfrm_pkg::TICK_MAX)) begin
         idle_in = idle_ff + 1'b1;
      end
      if (cmd.take_byte) begin
         idle_in  = '0;
         count_in = full ? eff_count : eff_count + 1'b1;
      end
      if (cmd.drop_one) begin
         head_in  = wrap_add(head_ff, CNT_W'(1));
         count_in = count_ff - 1'b1;
      end
      if (cmd.drop_len) begin
         head_in  = wrap_add(head_ff, len_ff[CNT_W-1:0]);
         count_in = count_ff - len_ff[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         idle_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idle_ff  <= idle_in;
      end
   end

   // length, CRC and byte index
   always_ff @(posedge clock) begin
      if (cmd.len_load) begin
         len_ff <= rd_ff;
      end
      if (cmd.rxlo_load) begin
         rxlo_ff <= rd_ff;
      end
      if (cmd.crc_init) begin
         crc_ff <= cfg.crc_seed;
      end else if (cmd.crc_step) begin
         crc_ff <= crc_byte(crc_ff, rd_ff, cfg.crc_poly);
      end
      if (cmd.crc_init) begin
         idx_ff <= '0;
      end else if (cmd.idx_emit) begin
         idx_ff <= IDX_W'(2);
      end else if (cmd.crc_step || cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push_notice || cmd.push_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_notice) begin
         rsp_ff.kind  <= stxfrm_pkg::KIND_NOTICE;
         rsp_ff.value <= 8'd0;
         rsp_ff.last  <= 1'b1;
      end else if (cmd.push_byte) begin
         rsp_ff.kind  <= stxfrm_pkg::KIND_PAYLOAD;
         rsp_ff.value <= rd_ff;
         rsp_ff.last  <= sts.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the controller
   assign sts.count_zero   = (count_ff == '0);
   assign sts.count_lt2    = (count_ff < CNT_W'(2));
   assign sts.head_is_stx  = (rd_ff == stxfrm_pkg::STX_BYTE);
   assign sts.len_big      = (len_ff > 8'(stxfrm_pkg::BUF_BYTES));
   assign sts.len_gt_count = (len_ff > 8'(count_ff));
   assign sts.len_small    = (len_ff < stxfrm_pkg::MIN_FRAME);
   assign sts.crc_done     = (8'(idx_ff) == (len_ff - stxfrm_pkg::CRC_BYTES));
   assign sts.crc_ok       = (crc_ff == {rd_ff, rxlo_ff});
   assign sts.emit_last    = (8'(idx_ff) == (len_ff - stxfrm_pkg::CRC_BYTES - 8'd1));
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

/* rtl/core/stx_length_crc_packet_framer.sv */
// ----------------------------------------------------------------------------
// stx_length_crc_packet_framer
// Serial packet framer: STX, length, command, id, data, CRC-16 (little
// endian). Good frames come out as payload bytes, bad ones as a notice.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_data  (action, rx_byte)
//   rsp_      out        rsp_valid/rsp_ready   rsp_data  (kind, value, last)
//   csr_      in         APB psel/penable      idle_timeout, crc_poly, crc_seed
//
//   a tick request is handled in the idle state; a byte request runs a
//   scan, and a rescan reads and drops each non-STX byte in turn
//   the CRC pass and the payload output each read a buffer byte, then use it,
//   set by the single buffer read port with registered data
//   a stalled response holds the sequencer, requests wait until it is idle
//   reset is synchronous and clears control state; the buffer needs no clear
// ----------------------------------------------------------------------------
module stx_length_crc_packet_framer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stxfrm_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stxfrm_pkg::rsp_type rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   stxfrm_pkg::cfg_type    cfg;
   stxfrm_pkg::cmd_type    cmd;
   stxfrm_pkg::status_type sts;

   // configuration registers
   stxfrm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   stxfrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // buffer, counters and output register
   stxfrm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_data.rx_byte),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/stxfrm_checker.sv */
// ----------------------------------------------------------------------------
// stxfrm_checker
// Port-level checks of the packet framer, bound to the top level.
// ----------------------------------------------------------------------------
module stxfrm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input stxfrm_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input stxfrm_pkg::rsp_type rsp_data
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a notice carries zero and closes the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == stxfrm_pkg::KIND_NOTICE)
         |-> (rsp_data.value == 8'd0) && rsp_data.last)
      else $error("malformed notice");

   // a tick finishes in the cycle it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action |=> req_ready)
      else $error("tick request left the framer busy");

   // a byte starts a scan, so the next request waits
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.action |=> !req_ready)
      else $error("byte request did not start a scan");

   // out of reset the framer is idle with nothing to send
   assert property (@(posedge clock)
      $fell(reset) |-> req_ready && !rsp_valid)
      else $error("framer not idle after reset");

endmodule

bind stx_length_crc_packet_framer stxfrm_checker u_checker (.*);
